// ===== hdl/ism_pkg.sv =====
// ----------------------------------------------------------------------------
// ism_pkg
// Shared sizes, types and helpers for the interval subscription matcher.
// ----------------------------------------------------------------------------
package ism_pkg;

	localparam int NUM_SUBS   = 1024;
	localparam int NUM_ATTRS  = 16;
	localparam int VALUE_BITS = 20;

	// Fixed field widths of the item and result ports.
	localparam int CMD_W   = 1;
	localparam int SUB_W   = 10;
	localparam int ATTR_W  = 4;
	localparam int FIELD_W = 20;
	localparam int MATCH_W = 11;

	// Slots are held sixteen to a memory word.
	localparam int LANES     = 16;
	localparam int LANE_W    = $clog2(LANES);
	localparam int LCNT_W    = $clog2(LANES + 1);
	localparam int WORDS     = (NUM_SUBS + LANES - 1) / LANES;
	localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int AIDX_W    = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
	localparam int CNT_W     = $clog2(NUM_SUBS + 1);

	localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
	localparam logic [CMD_W-1:0] CMD_PAIR   = 1'b1;

	typedef logic [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		value_t lo;
		value_t hi;
	} bounds_t;

	// Controller to datapath.
	typedef struct packed {
		logic              clr;
		logic              ins;
		logic              rd;
		logic              fin;
		logic [WORD_W-1:0] addr;
	} ism_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_busy;
		logic last;
	} ism_sts_t;

	function automatic logic [LCNT_W-1:0] popcount(input logic [LANES-1:0] v);
		logic [LCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < LANES; i++) begin
			n = n + LCNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

// ===== hdl/interval_subscription_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// interval_subscription_matcher_unit
// Interval constraint table matched against attribute/value events.
// ----------------------------------------------------------------------------
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | command, sub_id, attribute, low_bound,
//         |                      | high_bound, event_value, last_pair
// out     | out_valid / out_ready| match_count
//
// An insert writes its bounds and mask bit in the INS state. An event pair
// sweeps all 64 slot words of the constraint memories, one word per cycle;
// after the sweep the last pair hands the count to the output register.
// After reset a clearing pass over all 64 slot words runs before the first
// transfer. A waiting result does not block input; only a second finished
// count waits until the first has been taken.
module interval_subscription_matcher_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ism_pkg::CMD_W-1:0]    command,
	input  logic [ism_pkg::SUB_W-1:0]    sub_id,
	input  logic [ism_pkg::ATTR_W-1:0]   attribute,
	input  logic [ism_pkg::FIELD_W-1:0]  low_bound,
	input  logic [ism_pkg::FIELD_W-1:0]  high_bound,
	input  logic [ism_pkg::FIELD_W-1:0]  event_value,
	input  logic                         last_pair,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ism_pkg::MATCH_W-1:0]  match_count
);

	ism_pkg::ism_cmd_t cmd;
	ism_pkg::ism_sts_t sts;
	logic              accept;

	assign accept = in_valid && in_ready;

	ism_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	ism_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.accept      (accept),
		.command     (command),
		.sub_id      (sub_id),
		.attribute   (attribute),
		.low_bound   (low_bound),
		.high_bound  (high_bound),
		.event_value (event_value),
		.last_pair   (last_pair),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.match_count (match_count)
	);

endmodule

// ===== hdl/ism_ctrl.sv =====
// ----------------------------------------------------------------------------
// ism_ctrl
// Sequencer: clearing pass, insert write, word sweep and result hand-off.
// ----------------------------------------------------------------------------
module ism_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                command,
	input  ism_pkg::ism_sts_t   sts,
	output logic                in_ready,
	output ism_pkg::ism_cmd_t   cmd
);

	typedef enum logic [2:0] {CLEAR, IDLE, INS, SWEEP, DRAIN, DONE} state_t;

	state_t                    state_q;
	logic [ism_pkg::WORD_W-1:0] word_q;
	logic                      last_word;

	assign last_word = (word_q == ism_pkg::WORD_W'(ism_pkg::WORDS - 1));
	assign in_ready  = (state_q == IDLE);

	always_comb begin
		cmd      = '0;
		cmd.addr = word_q;
		unique case (state_q)
			CLEAR:   cmd.clr = 1'b1;
			INS:     cmd.ins = 1'b1;
			SWEEP:   cmd.rd  = 1'b1;
			DONE:    cmd.fin = !sts.out_busy;
			default: cmd     = cmd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			word_q  <= '0;
		end else begin
			unique case (state_q)
				CLEAR: begin
					word_q <= word_q + 1'b1;
					if (last_word) begin
						word_q  <= '0;
						state_q <= IDLE;
					end
				end
				IDLE: begin
					word_q <= '0;
					if (accept) begin
						state_q <= (command == ism_pkg::CMD_PAIR) ? SWEEP : INS;
					end
				end
				INS: state_q <= IDLE;
				SWEEP: begin
					word_q <= word_q + 1'b1;
					if (last_word) begin
						word_q  <= '0;
						state_q <= DRAIN;
					end
				end
				DRAIN: state_q <= sts.last ? DONE : IDLE;
				DONE: begin
					if (!sts.out_busy) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ism_dp.sv =====
// ----------------------------------------------------------------------------
// ism_dp
// Constraint memories, failed-slot bitmap, per-word check and match counter.
// ----------------------------------------------------------------------------
module ism_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ism_pkg::ism_cmd_t                  cmd,
	output ism_pkg::ism_sts_t                  sts,
	input  logic                               accept,
	input  logic [ism_pkg::CMD_W-1:0]          command,
	input  logic [ism_pkg::SUB_W-1:0]          sub_id,
	input  logic [ism_pkg::ATTR_W-1:0]         attribute,
	input  logic [ism_pkg::FIELD_W-1:0]        low_bound,
	input  logic [ism_pkg::FIELD_W-1:0]        high_bound,
	input  logic [ism_pkg::FIELD_W-1:0]        event_value,
	input  logic                               last_pair,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [ism_pkg::MATCH_W-1:0]        match_count
);

	localparam int LANES = ism_pkg::LANES;

	// Bounds per attribute and word, one lane per slot.
	ism_pkg::bounds_t [LANES-1:0]                bnd_mem [ism_pkg::NUM_ATTRS][ism_pkg::WORDS];
	// Which attributes each slot constrains.
	logic [LANES-1:0][ism_pkg::NUM_ATTRS-1:0]    mask_mem [ism_pkg::WORDS];
	logic [LANES-1:0]                            fail_mem [ism_pkg::WORDS];

	logic [ism_pkg::WORD_W-1:0]   wrd_q;
	logic [ism_pkg::LANE_W-1:0]   lane_q;
	logic [ism_pkg::AIDX_W-1:0]   aidx_q;
	logic                         sub_ok_q;
	logic                         attr_ok_q;
	ism_pkg::value_t              lo_q;
	ism_pkg::value_t              hi_q;
	ism_pkg::value_t              val_q;
	logic                         last_q;
	logic [ism_pkg::NUM_ATTRS-1:0] seen_q;
	logic [ism_pkg::CNT_W-1:0]    cnt_q;
	logic                         out_valid_q;
	logic [ism_pkg::MATCH_W-1:0]  match_q;

	ism_pkg::bounds_t [LANES-1:0]             bnd_s1;
	logic [LANES-1:0][ism_pkg::NUM_ATTRS-1:0] mask_s1;
	logic [LANES-1:0]                         fail_s1;
	logic [ism_pkg::WORD_W-1:0]               addr_s1;
	logic                                     vld_s1;

	logic [LANES-1:0] fail_new;
	logic [LANES-1:0] keep;

	assign sts.out_busy = out_valid_q && !out_ready;
	assign sts.last     = last_q;
	assign out_valid    = out_valid_q;
	assign match_count  = match_q;

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			wrd_q     <= ism_pkg::WORD_W'(sub_id >> ism_pkg::LANE_W);
			lane_q    <= sub_id[ism_pkg::LANE_W-1:0];
			aidx_q    <= ism_pkg::AIDX_W'(attribute);
			sub_ok_q  <= (32'(sub_id) < 32'(ism_pkg::NUM_SUBS));
			attr_ok_q <= (32'(attribute) < 32'(ism_pkg::NUM_ATTRS));
			lo_q      <= ism_pkg::VALUE_BITS'(low_bound);
			hi_q      <= ism_pkg::VALUE_BITS'(high_bound);
			val_q     <= ism_pkg::VALUE_BITS'(event_value);
			last_q    <= last_pair;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && sub_ok_q && attr_ok_q) begin
			bnd_mem[aidx_q][wrd_q][lane_q] <= '{lo: lo_q, hi: hi_q};
		end
		if (cmd.rd) begin
			bnd_s1 <= bnd_mem[aidx_q][cmd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mask_mem[cmd.addr] <= '0;
		end else if (cmd.ins && sub_ok_q && attr_ok_q) begin
			mask_mem[wrd_q][lane_q][aidx_q] <= 1'b1;
		end
		if (cmd.rd) begin
			mask_s1 <= mask_mem[cmd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			fail_mem[cmd.addr] <= '0;
		end else if (vld_s1) begin
			fail_mem[addr_s1] <= last_q ? '0 : fail_new;
		end
		if (cmd.rd) begin
			fail_s1 <= fail_mem[cmd.addr];
		end
	end

	// A slot fails on an excluded value, and on the last pair also when it
	// constrains an attribute the event never carried.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			fail_new[l] = fail_s1[l]
				| (attr_ok_q && mask_s1[l][aidx_q]
					&& (val_q < bnd_s1[l].lo || val_q > bnd_s1[l].hi))
				| (last_q && |(mask_s1[l] & ~seen_q));
			keep[l] = !fail_new[l]
				&& ((int'(addr_s1) * LANES + l) < ism_pkg::NUM_SUBS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			addr_s1     <= '0;
			seen_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			match_q     <= '0;
		end else begin
			vld_s1  <= cmd.rd;
			addr_s1 <= cmd.addr;
			if (accept && command == ism_pkg::CMD_PAIR
				&& 32'(attribute) < 32'(ism_pkg::NUM_ATTRS)) begin
				seen_q[ism_pkg::AIDX_W'(attribute)] <= 1'b1;
			end
			if (vld_s1 && last_q) begin
				cnt_q <= cnt_q + ism_pkg::CNT_W'(ism_pkg::popcount(keep));
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
				match_q     <= ism_pkg::MATCH_W'(cnt_q);
				cnt_q       <= '0;
				seen_q      <= '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
